// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands used by the checker file sfad_chk
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
    else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
    else $error("assertion failed");

`endif

// ===== sv/sfad_pkg.sv =====
// ----------------------------------------------------------------------------
// sfad_pkg
// shared types and constants of the attitude and depth state feedback unit
// ----------------------------------------------------------------------------
`default_nettype none

package sfad_pkg;

  localparam int GAIN_ROWS  = 3;
  localparam int STATE_LEN  = 12;
  localparam int GAIN_DEPTH = GAIN_ROWS * STATE_LEN;
  localparam int MEAS_DEPTH = 16;
  localparam int FETCH_BASE = 8;
  localparam int FETCH_CNT  = 8;
  localparam int WRAP_STEPS = 4;
  localparam int MAC_DRAIN  = 2;

  // pi and the surface tolerance scaled by 2^32
  localparam longint PI_Q32  = 64'sd13493037705;
  localparam longint TOL_Q32 = 64'sd429496730;

  localparam logic [1:0] CMD_LOAD_GAIN = 2'd0;
  localparam logic [1:0] CMD_LOAD_MEAS = 2'd1;
  localparam logic [1:0] CMD_COMPUTE   = 2'd2;
  localparam logic [1:0] CMD_RESERVED  = 2'd3;

  localparam logic [1:0] VM_DEPTH = 2'd0;
  localparam logic [1:0] VM_ALT   = 2'd1;
  localparam logic [1:0] VM_PITCH = 2'd2;
  localparam logic [1:0] VM_BAD   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_YAW  = 2'd1;
  localparam logic [1:0] ST_BAD_VERT = 2'd2;

  localparam logic [2:0] CFG_FIN_LIMIT       = 3'd0;
  localparam logic [2:0] CFG_ROLL_ENABLE     = 3'd1;
  localparam logic [2:0] CFG_PITCH_ACT_LIMIT = 3'd2;
  localparam logic [2:0] CFG_PITCH_REF_LIMIT = 3'd3;
  localparam logic [2:0] CFG_SURFACE_FORCE   = 3'd4;
  localparam logic [2:0] CFG_OFFSET_ENABLE   = 3'd5;
  localparam logic [2:0] CFG_DEPTH_BIAS      = 3'd6;
  localparam logic [2:0] CFG_DEPTH_ERR_LIMIT = 3'd7;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FETCH,
    S_FDRAIN,
    S_ERRA,
    S_ERRB,
    S_WRAP,
    S_WFIN,
    S_MAC,
    S_MDRAIN,
    S_FIN
  } state_t;

  typedef struct packed {
    logic       gain_we;
    logic       meas_we;
    logic       latch;
    logic       m_rd;
    logic [3:0] m_addr;
    logic [5:0] g_addr;
    logic       err_a;
    logic       err_b;
    logic       wrap_step;
    logic [1:0] wrap_ph;
    logic       wrap_fin;
    logic       mac_issue;
    logic [1:0] mac_row;
    logic [3:0] mac_col;
    logic       mac_first;
    logic       finish;
    logic       publish_bad;
    logic [1:0] bad_status;
  } dp_cmd_t;

  typedef struct packed {
    logic wrap_skip;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== sv/sfad_ctrl.sv =====
// ----------------------------------------------------------------------------
// sfad_ctrl
// sequencer: loads, mode checks, fetch, error forming, heading wrap, gain products, saturation
// ----------------------------------------------------------------------------
`default_nettype none

module sfad_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [1:0]       in_command,
  input  wire logic [1:0]       in_vertical_mode,
  input  wire logic             in_heading_mode_ok,
  output logic                  busy,
  output sfad_pkg::dp_cmd_t     cmd,
  input  sfad_pkg::dp_sts_t     sts
);
  import sfad_pkg::*;

  state_t     state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic [1:0] row_r, row_nxt;
  logic [3:0] col_r, col_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      row_r   <= '0;
      col_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (in_command)
            CMD_LOAD_GAIN: cmd.gain_we = 1'b1;
            CMD_LOAD_MEAS: cmd.meas_we = 1'b1;
            CMD_COMPUTE: begin
              priority if (!in_heading_mode_ok) begin
                cmd.publish_bad = 1'b1;
                cmd.bad_status  = ST_BAD_YAW;
              end else if (in_vertical_mode == VM_BAD) begin
                cmd.publish_bad = 1'b1;
                cmd.bad_status  = ST_BAD_VERT;
              end else begin
                cmd.latch = 1'b1;
                cnt_nxt   = '0;
                state_nxt = S_FETCH;
              end
            end
            default: ;
          endcase
        end
      end
      S_FETCH: begin
        cmd.m_rd   = 1'b1;
        cmd.m_addr = 4'(FETCH_BASE) | {1'b0, cnt_r[2:0]};
        if (cnt_r == 6'(FETCH_CNT - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_FDRAIN;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      S_FDRAIN: state_nxt = S_ERRA;
      S_ERRA: begin
        cmd.err_a = 1'b1;
        state_nxt = S_ERRB;
      end
      S_ERRB: begin
        cmd.err_b = 1'b1;
        cnt_nxt   = '0;
        // heading already inside the half turn skips the reduction
        state_nxt = sts.wrap_skip ? S_WFIN : S_WRAP;
      end
      S_WRAP: begin
        cmd.wrap_step = 1'b1;
        cmd.wrap_ph   = cnt_r[1:0];
        if (cnt_r == 6'(WRAP_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_WFIN;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      S_WFIN: begin
        cmd.wrap_fin = 1'b1;
        cnt_nxt      = '0;
        row_nxt      = '0;
        col_nxt      = '0;
        state_nxt    = S_MAC;
      end
      S_MAC: begin
        cmd.mac_issue = 1'b1;
        cmd.g_addr    = cnt_r;
        cmd.m_addr    = col_r;
        cmd.mac_row   = row_r;
        cmd.mac_col   = col_r;
        cmd.mac_first = (col_r == '0);
        if (col_r == 4'(STATE_LEN - 1)) begin
          col_nxt = '0;
          row_nxt = row_r + 2'd1;
        end else begin
          col_nxt = col_r + 4'd1;
        end
        if (cnt_r == 6'(GAIN_DEPTH - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_MDRAIN;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      S_MDRAIN: begin
        if (cnt_r == 6'(MAC_DRAIN - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_FIN;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/sfad_dp.sv =====
// ----------------------------------------------------------------------------
// sfad_dp
// stores, configuration, error forming, heading wrap, multiply-accumulate, saturation, results
// ----------------------------------------------------------------------------
`default_nettype none

module sfad_dp #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  sfad_pkg::dp_cmd_t       cmd,
  output sfad_pkg::dp_sts_t       sts,
  input  wire logic [5:0]         in_slot,
  input  wire logic signed [31:0] in_value,
  input  wire logic [1:0]         in_vertical_mode,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  output logic                    out_strobe,
  output logic [1:0]              out_status,
  output logic signed [31:0]      out_roll_torque,
  output logic signed [31:0]      out_pitch_torque,
  output logic signed [31:0]      out_yaw_torque
);
  import sfad_pkg::*;

  localparam longint PI_L   = (PI_Q32 + (longint'(1) << (31 - FRAC_BITS))) >>> (32 - FRAC_BITS);
  localparam longint TOL_L  = (TOL_Q32 + (longint'(1) << (31 - FRAC_BITS))) >>> (32 - FRAC_BITS);
  localparam longint TURN_L = 2 * PI_L;
  localparam int     ACC_W  = 70 - FRAC_BITS;

  // reciprocal of the full turn; the quotient estimate is low by at most one
  localparam int     RECIP_SH = 34;
  localparam longint RECIP_L  = (longint'(1) << RECIP_SH) / TURN_L;

  localparam logic signed [31:0] TOL_S   = 32'(TOL_L);
  localparam logic signed [32:0] PI_S33  = 33'(PI_L);
  localparam logic signed [33:0] PI_S34  = 34'(PI_L);
  localparam logic signed [34:0] PI_S35  = 35'(PI_L);
  localparam logic signed [34:0] TURN_S  = 35'(TURN_L);
  localparam logic [27:0]        TURN_Q  = 28'(TURN_L);
  localparam logic [31:0]        TURN_W  = 32'(TURN_L);
  localparam logic [23:0]        RECIP   = 24'(RECIP_L);
  localparam logic signed [65:0] HALF    = 66'(longint'(1) << (FRAC_BITS - 1));

  function automatic logic signed [ACC_W-1:0] sat(input logic signed [ACC_W-1:0] v,
                                                  input logic [30:0] lim);
    logic signed [ACC_W-1:0] lim_s;
    lim_s = ACC_W'($signed({1'b0, lim}));
    if (v > lim_s) return lim_s;
    if (v < -lim_s) return -lim_s;
    return v;
  endfunction

  // configuration
  logic [30:0]        fin_limit_r;
  logic               roll_enable_r;
  logic [30:0]        pitch_act_limit_r;
  logic [30:0]        pitch_ref_limit_r;
  logic               surface_force_r;
  logic               offset_enable_r;
  logic signed [31:0] depth_bias_r;
  logic [30:0]        depth_err_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_limit_r       <= 31'd983040;
      roll_enable_r     <= 1'b1;
      pitch_act_limit_r <= 31'd17157;
      pitch_ref_limit_r <= 31'd11438;
      surface_force_r   <= 1'b0;
      offset_enable_r   <= 1'b0;
      depth_bias_r      <= '0;
      depth_err_limit_r <= 31'd131072;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FIN_LIMIT:       fin_limit_r       <= cfg_data[30:0];
        CFG_ROLL_ENABLE:     roll_enable_r     <= cfg_data[0];
        CFG_PITCH_ACT_LIMIT: pitch_act_limit_r <= cfg_data[30:0];
        CFG_PITCH_REF_LIMIT: pitch_ref_limit_r <= cfg_data[30:0];
        CFG_SURFACE_FORCE:   surface_force_r   <= cfg_data[0];
        CFG_OFFSET_ENABLE:   offset_enable_r   <= cfg_data[0];
        CFG_DEPTH_BIAS:      depth_bias_r      <= $signed(cfg_data);
        CFG_DEPTH_ERR_LIMIT: depth_err_limit_r <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // gain and measurement stores
  logic signed [31:0] gain_mem [GAIN_DEPTH];
  logic signed [31:0] meas_mem [MEAS_DEPTH];
  logic signed [31:0] gain_q_r;
  logic signed [31:0] meas_q_r;

  always_ff @(posedge clk) begin
    if (cmd.gain_we && (in_slot < 6'(GAIN_DEPTH))) gain_mem[in_slot] <= in_value;
    gain_q_r <= gain_mem[cmd.g_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.meas_we && (in_slot[5:4] == 2'b00)) meas_mem[in_slot[3:0]] <= in_value;
    meas_q_r <= meas_mem[cmd.m_addr];
  end

  // captured slots 8..15
  logic               rd_pend_r;
  logic [2:0]         rd_idx_r;
  logic signed [31:0] mcap_r [FETCH_CNT];
  logic [1:0]         vmode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) rd_pend_r <= 1'b0;
    else        rd_pend_r <= cmd.m_rd;
    rd_idx_r <= cmd.m_addr[2:0];
    if (rd_pend_r) mcap_r[rd_idx_r] <= meas_q_r;
    if (cmd.latch) vmode_r <= in_vertical_mode;
  end

  // error forming, first stage
  logic signed [31:0] m8, m9, m10, m11, m12, m13, m14, m15;
  logic               m13_low;
  logic               use_off;
  logic signed [33:0] dep_raw;
  logic signed [32:0] hd;
  logic               hd_gt, hd_lt;

  assign m8  = mcap_r[0];
  assign m9  = mcap_r[1];
  assign m10 = mcap_r[2];
  assign m11 = mcap_r[3];
  assign m12 = mcap_r[4];
  assign m13 = mcap_r[5];
  assign m14 = mcap_r[6];
  assign m15 = mcap_r[7];

  assign m13_low = (m13 < TOL_S);
  assign use_off = offset_enable_r &&
                   !((vmode_r == VM_DEPTH) && m13_low && (depth_bias_r > 32'sd0));
  assign hd      = 33'(m11) - 33'(m14);
  assign hd_gt   = (hd > PI_S33);
  assign hd_lt   = (hd < -PI_S33);

  always_comb begin
    unique case (vmode_r)
      VM_DEPTH: dep_raw = 34'(m8) - 34'(m13);
      VM_ALT:   dep_raw = 34'(m9) - 34'(m15);
      default:  dep_raw = '0;
    endcase
  end

  logic signed [33:0] dep_off_r;
  logic signed [32:0] pdiff_r;
  logic               surf_r;
  logic signed [32:0] hd_r;
  logic               wgt_r, wlt_r;
  logic [31:0]        y_r;
  logic [55:0]        qp_r;
  logic [49:0]        qt_r;
  logic [31:0]        rem_r;
  logic signed [32:0] xv9_r;
  logic signed [31:0] depth_c_r;
  logic signed [31:0] pitch_c_r;
  logic signed [32:0] xv11_r;

  logic signed [34:0] rem_s;
  logic signed [34:0] wrap_hi, wrap_lo;

  assign rem_s   = $signed({3'b000, rem_r});
  assign wrap_hi = rem_s + PI_S35 + 35'sd1 - TURN_S;
  assign wrap_lo = TURN_S - PI_S35 - 35'sd1 - rem_s;

  assign sts.wrap_skip = !(wgt_r || wlt_r);

  always_ff @(posedge clk) begin
    if (cmd.err_a) begin
      dep_off_r <= use_off ? (dep_raw - 34'(depth_bias_r)) : dep_raw;
      pdiff_r   <= 33'(m10) - 33'(m13);
      surf_r    <= (vmode_r == VM_DEPTH) && m13_low && surface_force_r;
      hd_r      <= hd;
      wgt_r     <= hd_gt;
      wlt_r     <= hd_lt;
      xv9_r     <= -33'(m12);
      rem_r     <= '0;
      priority if (hd_gt) y_r <= 32'(34'(hd) - PI_S34 - 34'sd1);
      else if (hd_lt)     y_r <= 32'(-PI_S34 - 34'(hd) - 34'sd1);
      else                y_r <= '0;
    end
    if (cmd.err_b) begin
      if (surf_r) begin
        depth_c_r <= '0;
        pitch_c_r <= -$signed({1'b0, pitch_ref_limit_r});
      end else begin
        depth_c_r <= 32'(sat(ACC_W'(dep_off_r), depth_err_limit_r));
        pitch_c_r <= (vmode_r == VM_PITCH) ?
                     32'(sat(ACC_W'(pdiff_r), pitch_ref_limit_r)) : 32'sd0;
      end
    end
    // remainder by the full turn: reciprocal estimate, back-multiply, subtract, one fix-up
    if (cmd.wrap_step) begin
      unique case (cmd.wrap_ph)
        2'd0:    qp_r  <= y_r * RECIP;
        2'd1:    qt_r  <= qp_r[55:RECIP_SH] * TURN_Q;
        2'd2:    rem_r <= y_r - 32'(qt_r);
        default: if (rem_r >= TURN_W) rem_r <= rem_r - TURN_W;
      endcase
    end
    if (cmd.wrap_fin) begin
      priority if (wgt_r) xv11_r <= 33'(wrap_hi);
      else if (wlt_r)     xv11_r <= 33'(wrap_lo);
      else                xv11_r <= hd_r;
    end
  end

  // multiply-accumulate pipeline
  logic               s1_v_r, s1_first_r;
  logic [1:0]         s1_row_r;
  logic [3:0]         s1_col_r;
  logic               s2_v_r, s2_first_r;
  logic [1:0]         s2_row_r;
  logic signed [32:0] xv_sel;
  logic signed [64:0] prod_c;
  logic signed [64:0] prod_r;
  logic signed [65:0] rnd;
  logic signed [ACC_W-1:0] term;
  logic signed [ACC_W-1:0] acc_r [GAIN_ROWS];

  always_comb begin
    priority if (s1_col_r < 4'(FETCH_BASE)) xv_sel = 33'(meas_q_r);
    else if (s1_col_r == 4'd8)              xv_sel = 33'(depth_c_r);
    else if (s1_col_r == 4'd9)              xv_sel = xv9_r;
    else if (s1_col_r == 4'd10)             xv_sel = 33'(pitch_c_r);
    else                                    xv_sel = xv11_r;
  end

  assign prod_c = gain_q_r * xv_sel;
  assign rnd    = 66'(prod_r) + HALF;
  assign term   = ACC_W'(rnd >>> FRAC_BITS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= cmd.mac_issue;
      s2_v_r <= s1_v_r;
    end
    s1_first_r <= cmd.mac_first;
    s1_row_r   <= cmd.mac_row;
    s1_col_r   <= cmd.mac_col;
    s2_first_r <= s1_first_r;
    s2_row_r   <= s1_row_r;
    prod_r     <= prod_c;
    if (s2_v_r) acc_r[s2_row_r] <= s2_first_r ? term : (acc_r[s2_row_r] + term);
  end

  // saturation and result registers
  logic signed [ACC_W-1:0] roll_sat, pitch_sat, yaw_sat;
  logic signed [31:0]      held_roll_r;
  logic                    strobe_r;
  logic [1:0]              status_r;
  logic signed [31:0]      roll_r, pitch_r, yaw_r;

  assign roll_sat  = sat(acc_r[0], fin_limit_r);
  assign pitch_sat = sat(acc_r[1], pitch_act_limit_r);
  assign yaw_sat   = sat(acc_r[2], fin_limit_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r    <= 1'b0;
      held_roll_r <= '0;
    end else begin
      strobe_r <= cmd.finish || cmd.publish_bad;
      if (cmd.finish && roll_enable_r) held_roll_r <= 32'(roll_sat);
    end
    if (cmd.finish) begin
      status_r <= ST_OK;
      roll_r   <= roll_enable_r ? 32'(roll_sat) : held_roll_r;
      pitch_r  <= 32'(pitch_sat);
      yaw_r    <= 32'(yaw_sat);
    end else if (cmd.publish_bad) begin
      status_r <= cmd.bad_status;
      roll_r   <= '0;
      pitch_r  <= '0;
      yaw_r    <= '0;
    end
  end

  assign out_strobe       = strobe_r;
  assign out_status       = status_r;
  assign out_roll_torque  = roll_r;
  assign out_pitch_torque = pitch_r;
  assign out_yaw_torque   = yaw_r;

endmodule

`default_nettype wire

// ===== sv/state_feedback_attitude_depth_control_unit.sv =====
// ----------------------------------------------------------------------------
// state_feedback_attitude_depth_control_unit
// 3x12 state feedback for roll, pitch and yaw torques in signed fixed point
// ----------------------------------------------------------------------------
// channel   ports                          handshake
// input     in_command/slot/value/...      start, taken when busy is low
// result    out_status, out_*_torque       out_strobe, one cycle, no stall
// config    cfg_index, cfg_data            cfg_we, written at once
//
// load requests keep busy low and give no result
// a compute request keeps busy high through 8 slot reads, a reciprocal reduction
// by the full turn when the heading needs a wrap, and 36 products through the
// multiply-accumulate multiplier; the result follows busy
// a bad mode gives its status result the cycle after the request
// synchronous active-low reset; the stores hold no reset values
// ----------------------------------------------------------------------------
`default_nettype none

module state_feedback_attitude_depth_control_unit #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         in_command,
  input  wire logic [5:0]         in_slot,
  input  wire logic signed [31:0] in_value,
  input  wire logic [1:0]         in_vertical_mode,
  input  wire logic               in_heading_mode_ok,
  output logic                    out_strobe,
  output logic [1:0]              out_status,
  output logic signed [31:0]      out_roll_torque,
  output logic signed [31:0]      out_pitch_torque,
  output logic signed [31:0]      out_yaw_torque,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);
  import sfad_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  sfad_ctrl u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .in_command         (in_command),
    .in_vertical_mode   (in_vertical_mode),
    .in_heading_mode_ok (in_heading_mode_ok),
    .busy               (busy),
    .cmd                (cmd),
    .sts                (sts)
  );

  sfad_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_slot          (in_slot),
    .in_value         (in_value),
    .in_vertical_mode (in_vertical_mode),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_strobe       (out_strobe),
    .out_status       (out_status),
    .out_roll_torque  (out_roll_torque),
    .out_pitch_torque (out_pitch_torque),
    .out_yaw_torque   (out_yaw_torque)
  );

endmodule

`default_nettype wire

// ===== sv/sfad_chk.sv =====
// ----------------------------------------------------------------------------
// sfad_chk
// port-level checks on request and result timing
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sfad_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [1:0]  in_command,
  input wire logic [1:0]  in_vertical_mode,
  input wire logic        in_heading_mode_ok,
  input wire logic        out_strobe,
  input wire logic [1:0]  out_status,
  input wire logic [31:0] out_roll_torque,
  input wire logic [31:0] out_pitch_torque,
  input wire logic [31:0] out_yaw_torque
);
  import sfad_pkg::*;

  logic bad_res;
  logic torq_zero;
  logic take_cmp;
  logic take_bad_yaw;
  logic take_run;

  assign bad_res      = out_strobe && (out_status != ST_OK);
  assign torq_zero    = (out_roll_torque == '0) && (out_pitch_torque == '0) &&
                        (out_yaw_torque == '0);
  assign take_cmp     = start && !busy && (in_command == CMD_COMPUTE);
  assign take_bad_yaw = take_cmp && !in_heading_mode_ok;
  assign take_run     = take_cmp && in_heading_mode_ok && (in_vertical_mode != VM_BAD);

  // a failing status carries zero torques
  `ASSERT_IMPLIES(a_bad_zero, clk, rst_n, bad_res, torq_zero)

  // end of a compute run always shows its result
  `ASSERT_IMPLIES(a_done_strobe, clk, rst_n, $past(rst_n) && $fell(busy), out_strobe)

  // yaw mode is checked first
  `ASSERT_NEXT(a_bad_yaw, clk, rst_n, take_bad_yaw, out_strobe && (out_status == ST_BAD_YAW))

  // a valid compute request starts a run and shows nothing right away
  `ASSERT_NEXT(a_run_starts, clk, rst_n, take_run, busy && !out_strobe)

endmodule

bind state_feedback_attitude_depth_control_unit sfad_chk u_sfad_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .in_command         (in_command),
  .in_vertical_mode   (in_vertical_mode),
  .in_heading_mode_ok (in_heading_mode_ok),
  .out_strobe         (out_strobe),
  .out_status         (out_status),
  .out_roll_torque    (out_roll_torque),
  .out_pitch_torque   (out_pitch_torque),
  .out_yaw_torque     (out_yaw_torque)
);

`default_nettype wire
